FILE: design/hbrs_pkg.sv
// Shared types, codes and constants of the H-bridge relay sequencer.
package hbrs_pkg;

  // Default width of the half-period counter
  localparam int unsigned PERIOD_COUNTER_WIDTH = 24;

  // Field widths
  localparam int unsigned MODE_W  = 1;
  localparam int unsigned HALF_W  = 24;
  localparam int unsigned DELAY_W = 20;
  localparam int unsigned STATE_W = 2;
  localparam int unsigned RELAY_W = 4;

  // Configuration bus
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 4;

  // Relay delay after reset: 10 ms in microseconds
  localparam int unsigned RELAY_DELAY_MS = 10;
  localparam logic [DELAY_W-1:0] RELAY_DELAY_RESET = DELAY_W'(RELAY_DELAY_MS * 1000);

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_HALF  = 2'd1,
    REG_DELAY = 2'd2
  } reg_idx_e;

  // Requested bridge states
  typedef enum logic [STATE_W-1:0] {
    ST_GROUND = 2'd0,
    ST_HVA    = 2'd1,
    ST_HVB    = 2'd2,
    ST_HIGHZ  = 2'd3
  } bridge_state_e;

  // Sequencer phases
  typedef enum logic [1:0] {
    PH_STANDBY    = 2'd0,
    PH_DISCONNECT = 2'd1,
    PH_RECONNECT  = 2'd2
  } phase_e;

  // Relay patterns: bit 0 low A, bit 1 low B, bit 2 high A, bit 3 high B
  localparam logic [RELAY_W-1:0] PAT_GND   = 4'h3;
  localparam logic [RELAY_W-1:0] PAT_HVA   = 4'h6;
  localparam logic [RELAY_W-1:0] PAT_HVB   = 4'h9;
  localparam logic [RELAY_W-1:0] PAT_HIGHZ = 4'h0;

  // Map a requested state to its relay pattern
  function automatic logic [RELAY_W-1:0] decode_state(input logic [STATE_W-1:0] s);
    logic [RELAY_W-1:0] pat;
    case (bridge_state_e'(s))
      ST_HVA:   pat = PAT_HVA;
      ST_HVB:   pat = PAT_HVB;
      ST_HIGHZ: pat = PAT_HIGHZ;
      default:  pat = PAT_GND;
    endcase
    return pat;
  endfunction

endpackage

FILE: design/hbrs_if.sv
// Request and drive channel interfaces of the H-bridge relay sequencer.
interface hbrs_req_if;
  logic                          valid;
  logic                          ready;
  logic                          request_valid;
  logic [hbrs_pkg::STATE_W-1:0]  requested_state;

  modport source (output valid, request_valid, requested_state, input ready);
  modport sink   (input valid, request_valid, requested_state, output ready);
endinterface

interface hbrs_drv_if;
  logic                          valid;
  logic                          ready;
  logic                          drive_low_a;
  logic                          drive_low_b;
  logic                          drive_high_a;
  logic                          drive_high_b;
  logic                          busy_res;
  logic [hbrs_pkg::STATE_W-1:0]  last_request;

  modport source (output valid, drive_low_a, drive_low_b, drive_high_a, drive_high_b,
                  busy_res, last_request, input ready);
  modport sink   (input valid, drive_low_a, drive_low_b, drive_high_a, drive_high_b,
                  busy_res, last_request, output ready);
endinterface

FILE: design/h_bridge_relay_sequencer.sv
// Top level of the H-bridge relay sequencer with break-before-make switching.
//
// Each transfer on req_if is one microsecond tick and yields exactly one
// transfer on drv_if carrying the relay drives after that tick. The
// sequencer state and an output register update at the same edge: the drives
// are offered in the cycle after the tick, and a new tick is taken in every
// cycle while drv_if is ready or the output register is empty. On a state
// change the relays that must be off open on that tick; the new ones close
// once more than relay_delay_us ticks have passed (busy_res is high in
// between). In frequency mode the target alternates HVB, HVA, ... each time
// more than half_period_us ticks have passed; requests made meanwhile are
// held and the latest acts when manual mode returns. Registers: mode at 0x0,
// half period at 0x4, relay delay at 0x8; write them only while idle.
module h_bridge_relay_sequencer #(
  parameter int unsigned PERIOD_COUNTER_WIDTH = hbrs_pkg::PERIOD_COUNTER_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hbrs_req_if.sink                      req_if,
  hbrs_drv_if.source                    drv_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbrs_pkg::APB_AW-1:0]   paddr,
  input  logic [hbrs_pkg::APB_DW-1:0]   pwdata,
  output logic [hbrs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned PW = PERIOD_COUNTER_WIDTH;
  localparam int unsigned LW = (PW > hbrs_pkg::HALF_W) ? PW : hbrs_pkg::HALF_W;

  // Configuration registers
  logic                             mode_q, mode_d;
  logic [hbrs_pkg::HALF_W-1:0]      half_q, half_d;
  logic [hbrs_pkg::DELAY_W-1:0]     delay_cfg_q, delay_cfg_d;

  // Sequencer state
  logic [hbrs_pkg::RELAY_W-1:0]     relay_q, relay_d;
  logic [hbrs_pkg::RELAY_W-1:0]     target_q, target_d;
  hbrs_pkg::phase_e                 phase_q, phase_d;
  logic [hbrs_pkg::DELAY_W-1:0]     wait_q, wait_d;
  logic [PW-1:0]                    period_q, period_d;
  logic                             toggle_q, toggle_d;
  logic                             pend_valid_q, pend_valid_d;
  logic [hbrs_pkg::STATE_W-1:0]     pend_state_q, pend_state_d;

  // Output register
  logic                             out_valid_q;
  logic [hbrs_pkg::RELAY_W-1:0]     out_relay_q;
  logic                             out_busy_q;
  logic [hbrs_pkg::STATE_W-1:0]     out_req_q;

  logic                             in_xfer;
  logic                             cfg_wr;
  hbrs_pkg::reg_idx_e               cfg_idx;
  logic                             mode_wr;
  logic [LW-1:0]                    half_ext;
  logic [LW-1:0]                    half_new_ext;
  logic [PW-1:0]                    limit;
  logic [PW-1:0]                    limit_new;
  logic                             change;
  logic [hbrs_pkg::STATE_W-1:0]     new_state;
  hbrs_pkg::phase_e                 phase_eff;

  // Handshakes
  assign req_if.ready = !out_valid_q || drv_if.ready;
  assign in_xfer      = req_if.valid && req_if.ready;
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign cfg_idx      = hbrs_pkg::reg_idx_e'(paddr[3:2]);

  // Read back registers
  always_comb begin
    case (cfg_idx)
      hbrs_pkg::REG_MODE:  prdata = hbrs_pkg::APB_DW'(mode_q);
      hbrs_pkg::REG_HALF:  prdata = hbrs_pkg::APB_DW'(half_q);
      hbrs_pkg::REG_DELAY: prdata = hbrs_pkg::APB_DW'(delay_cfg_q);
      default:             prdata = '0;
    endcase
  end

  // Period limits from the current and the newly written half period
  assign half_ext     = LW'(half_q);
  assign limit        = half_ext[PW-1:0];
  assign half_new_ext = LW'(half_d);
  assign limit_new    = half_new_ext[PW-1:0];

  // Register writes
  always_comb begin
    mode_d      = mode_q;
    half_d      = half_q;
    delay_cfg_d = delay_cfg_q;
    mode_wr     = 1'b0;
    if (cfg_wr) begin
      case (cfg_idx)
        hbrs_pkg::REG_MODE: begin
          mode_d  = pwdata[0];
          mode_wr = 1'b1;
        end
        hbrs_pkg::REG_HALF: begin
          half_d  = pwdata[hbrs_pkg::HALF_W-1:0];
          mode_wr = 1'b1;
        end
        hbrs_pkg::REG_DELAY: delay_cfg_d = pwdata[hbrs_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
    // Frequency mode with no half period falls back to manual ground
    if (mode_wr && mode_d && (limit_new == '0)) begin
      mode_d = 1'b0;
    end
  end

  // One tick of the sequencer
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_state_d = pend_state_q;
    period_d     = period_q;
    toggle_d     = toggle_q;
    target_d     = target_q;
    relay_d      = relay_q;
    wait_d       = wait_q;
    phase_d      = phase_q;
    change       = 1'b0;
    new_state    = hbrs_pkg::ST_GROUND;
    phase_eff    = phase_q;

    if (in_xfer) begin
      // Latch a new request; the latest one wins
      if (req_if.request_valid) begin
        pend_valid_d = 1'b1;
        pend_state_d = req_if.requested_state;
      end

      // Pick up a change from a request or from the period timer
      if (!mode_q) begin
        if (pend_valid_d) begin
          pend_valid_d = 1'b0;
          change       = 1'b1;
          new_state    = pend_state_d;
        end
      end else if (period_q >= limit) begin
        period_d  = '0;
        toggle_d  = ~toggle_q;
        change    = 1'b1;
        new_state = toggle_d ? hbrs_pkg::ST_HVB : hbrs_pkg::ST_HVA;
      end else begin
        period_d = period_q + PW'(1);
      end

      if (change) begin
        target_d  = hbrs_pkg::decode_state(new_state);
        phase_eff = hbrs_pkg::PH_DISCONNECT;
      end
      phase_d = phase_eff;

      // Break first, then make after the delay
      case (phase_eff)
        hbrs_pkg::PH_STANDBY: ;
        hbrs_pkg::PH_DISCONNECT: begin
          relay_d = relay_q & target_d;
          wait_d  = '0;
          phase_d = hbrs_pkg::PH_RECONNECT;
        end
        hbrs_pkg::PH_RECONNECT: begin
          if (wait_q >= delay_cfg_q) begin
            relay_d = relay_q | target_d;
            phase_d = hbrs_pkg::PH_STANDBY;
          end else begin
            wait_d = wait_q + hbrs_pkg::DELAY_W'(1);
          end
        end
        default: begin
          target_d = hbrs_pkg::PAT_GND;
          phase_d  = hbrs_pkg::PH_DISCONNECT;
        end
      endcase
    end

    // Mode or half-period write restarts the alternation
    if (mode_wr) begin
      period_d = '0;
      toggle_d = 1'b0;
      if (mode_q != mode_d || (cfg_idx == hbrs_pkg::REG_MODE && pwdata[0])) begin
        if (mode_d == 1'b0 && (cfg_idx == hbrs_pkg::REG_HALF || pwdata[0])) begin
          pend_state_d = hbrs_pkg::ST_GROUND;
          pend_valid_d = 1'b1;
        end
      end else if (mode_q && !mode_d) begin
        pend_state_d = hbrs_pkg::ST_GROUND;
        pend_valid_d = 1'b1;
      end
    end
  end

  // Configuration and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      half_q       <= '0;
      delay_cfg_q  <= hbrs_pkg::RELAY_DELAY_RESET;
      relay_q      <= hbrs_pkg::PAT_GND;
      target_q     <= hbrs_pkg::PAT_GND;
      phase_q      <= hbrs_pkg::PH_STANDBY;
      wait_q       <= '0;
      period_q     <= '0;
      toggle_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_state_q <= hbrs_pkg::ST_GROUND;
    end else begin
      mode_q       <= mode_d;
      half_q       <= half_d;
      delay_cfg_q  <= delay_cfg_d;
      relay_q      <= relay_d;
      target_q     <= target_d;
      phase_q      <= phase_d;
      wait_q       <= wait_d;
      period_q     <= period_d;
      toggle_q     <= toggle_d;
      pend_valid_q <= pend_valid_d;
      pend_state_q <= pend_state_d;
    end
  end

  // Output register: load on each tick, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (drv_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_relay_q <= relay_d;
      out_busy_q  <= (phase_d != hbrs_pkg::PH_STANDBY);
      out_req_q   <= pend_state_d;
    end
  end

  assign drv_if.valid        = out_valid_q;
  assign drv_if.drive_low_a  = out_relay_q[0];
  assign drv_if.drive_low_b  = out_relay_q[1];
  assign drv_if.drive_high_a = out_relay_q[2];
  assign drv_if.drive_high_b = out_relay_q[3];
  assign drv_if.busy_res     = out_busy_q;
  assign drv_if.last_request = out_req_q;

endmodule

FILE: design/hbrs_checker.sv
// Port-level checks of the H-bridge relay sequencer and their binding.
module hbrs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_ready,
  input logic                          drv_valid,
  input logic                          drv_ready,
  input logic                          drive_low_a,
  input logic                          drive_low_b,
  input logic                          drive_high_a,
  input logic                          drive_high_b,
  input logic                          busy_res,
  input logic [hbrs_pkg::STATE_W-1:0]  last_request
);

  logic drv_xfer;

  assign drv_xfer = drv_valid && drv_ready;

  // Never close both relays of one leg
  a_no_shoot_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_valid |-> !(drive_low_a && drive_high_a) && !(drive_low_b && drive_high_b))
    else $error("both relays of one bridge leg closed");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_valid && !drv_ready |=> drv_valid && $stable(drive_low_a) && $stable(drive_low_b)
      && $stable(drive_high_a) && $stable(drive_high_b) && $stable(busy_res)
      && $stable(last_request))
    else $error("stalled result changed");

  // Take a tick whenever the output register is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drv_valid |-> req_ready)
    else $error("input stalled with empty output register");

  // Close relays only on the transfer that ends the wait
  a_make_after_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_xfer ##1 drv_xfer |-> !(($rose(drive_low_a) || $rose(drive_low_b)
      || $rose(drive_high_a) || $rose(drive_high_b)) && busy_res))
    else $error("relay closed while still waiting");

endmodule

bind h_bridge_relay_sequencer hbrs_checker u_hbrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready    (req_if.ready),
  .drv_valid    (drv_if.valid),
  .drv_ready    (drv_if.ready),
  .drive_low_a  (drv_if.drive_low_a),
  .drive_low_b  (drv_if.drive_low_b),
  .drive_high_a (drv_if.drive_high_a),
  .drive_high_b (drv_if.drive_high_b),
  .busy_res     (drv_if.busy_res),
  .last_request (drv_if.last_request)
);

FILE: sim/tb_h_bridge_relay_sequencer.sv
// Self-checking testbench of the H-bridge relay sequencer: directed and random ticks.
module tb_h_bridge_relay_sequencer;

  // Relay drives and status carried by one drive transfer
  typedef struct packed {
    logic                         low_a;
    logic                         low_b;
    logic                         high_a;
    logic                         high_b;
    logic                         busy;
    logic [hbrs_pkg::STATE_W-1:0] last;
  } drive_t;

  // Tracks the sequencer state and checks every drive transfer against it
  class relay_scoreboard;
    logic                                      freq_mode;
    logic [hbrs_pkg::PERIOD_COUNTER_WIDTH-1:0] half_us;
    logic [hbrs_pkg::DELAY_W-1:0]              delay_us;
    logic [hbrs_pkg::RELAY_W-1:0]              relays;
    logic [hbrs_pkg::RELAY_W-1:0]              target;
    hbrs_pkg::phase_e                          seq;
    logic [hbrs_pkg::DELAY_W-1:0]              delay_cnt;
    logic [hbrs_pkg::PERIOD_COUNTER_WIDTH-1:0] period_cnt;
    logic                                      toggle;
    logic                                      pend_v;
    logic [hbrs_pkg::STATE_W-1:0]              pend_st;
    drive_t                                    drive_due[$];
    int                                        errors;

    function new();
      freq_mode  = 1'b0;
      half_us    = '0;
      delay_us   = hbrs_pkg::RELAY_DELAY_RESET;
      relays     = hbrs_pkg::PAT_GND;
      target     = hbrs_pkg::PAT_GND;
      seq        = hbrs_pkg::PH_STANDBY;
      delay_cnt  = '0;
      period_cnt = '0;
      toggle     = 1'b0;
      pend_v     = 1'b0;
      pend_st    = hbrs_pkg::ST_GROUND;
      errors     = 0;
    endfunction

    // Restart the alternation; a frequency mode without a period falls back to ground
    function void mode_touched();
      period_cnt = '0;
      toggle     = 1'b0;
      if (freq_mode && half_us == '0) begin
        freq_mode = 1'b0;
        pend_st   = hbrs_pkg::ST_GROUND;
        pend_v    = 1'b1;
      end
    endfunction

    function void write_reg(hbrs_pkg::reg_idx_e idx, logic [hbrs_pkg::APB_DW-1:0] value);
      case (idx)
        hbrs_pkg::REG_MODE: begin
          freq_mode = value[0];
          mode_touched();
        end
        hbrs_pkg::REG_HALF: begin
          half_us = value[hbrs_pkg::PERIOD_COUNTER_WIDTH-1:0];
          mode_touched();
        end
        hbrs_pkg::REG_DELAY: delay_us = value[hbrs_pkg::DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance one microsecond tick and queue the drives it leaves behind
    function void note_tick(logic rv, logic [hbrs_pkg::STATE_W-1:0] st);
      logic                         chg;
      logic [hbrs_pkg::STATE_W-1:0] nxt;
      drive_t                       e;
      chg = 1'b0;
      nxt = hbrs_pkg::ST_GROUND;
      if (rv) begin
        pend_v  = 1'b1;
        pend_st = st;
      end
      if (!freq_mode) begin
        if (pend_v) begin
          pend_v = 1'b0;
          chg    = 1'b1;
          nxt    = pend_st;
        end
      end else if (period_cnt >= half_us) begin
        period_cnt = '0;
        toggle     = ~toggle;
        chg        = 1'b1;
        nxt        = toggle ? hbrs_pkg::ST_HVB : hbrs_pkg::ST_HVA;
      end else begin
        period_cnt++;
      end
      if (chg) begin
        case (hbrs_pkg::bridge_state_e'(nxt))
          hbrs_pkg::ST_HVA:   target = hbrs_pkg::PAT_HVA;
          hbrs_pkg::ST_HVB:   target = hbrs_pkg::PAT_HVB;
          hbrs_pkg::ST_HIGHZ: target = hbrs_pkg::PAT_HIGHZ;
          default:            target = hbrs_pkg::PAT_GND;
        endcase
        seq = hbrs_pkg::PH_DISCONNECT;
      end
      // Break first, then make once the relay delay has run out
      case (seq)
        hbrs_pkg::PH_STANDBY: ;
        hbrs_pkg::PH_DISCONNECT: begin
          relays    = relays & target;
          delay_cnt = '0;
          seq       = hbrs_pkg::PH_RECONNECT;
        end
        hbrs_pkg::PH_RECONNECT: begin
          if (delay_cnt >= delay_us) begin
            relays = relays | target;
            seq    = hbrs_pkg::PH_STANDBY;
          end else begin
            delay_cnt++;
          end
        end
        default: begin
          target = hbrs_pkg::PAT_GND;
          seq    = hbrs_pkg::PH_DISCONNECT;
        end
      endcase
      e.low_a  = relays[0];
      e.low_b  = relays[1];
      e.high_a = relays[2];
      e.high_b = relays[3];
      e.busy   = (seq != hbrs_pkg::PH_STANDBY);
      e.last   = pend_st;
      drive_due.push_back(e);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("%0t: %s differs: expected %0d, actual %0d", $realtime, field, want, got);
      end
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (drive_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: drive transfer with nothing due: actual %p", $realtime, got);
        return;
      end
      want = drive_due.pop_front();
      compare("drive_low_a", want.low_a, got.low_a);
      compare("drive_low_b", want.low_b, got.low_b);
      compare("drive_high_a", want.high_a, got.high_a);
      compare("drive_high_b", want.high_b, got.high_b);
      compare("busy_res", want.busy, got.busy);
      compare("last_request", want.last, got.last);
    endfunction

    function int outstanding();
      return drive_due.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [hbrs_pkg::APB_AW-1:0] paddr;
  logic [hbrs_pkg::APB_DW-1:0] pwdata;
  logic [hbrs_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  hbrs_req_if req_ch ();
  hbrs_drv_if drv_ch ();

  relay_scoreboard sb;
  int              idle_pct;
  int              stall_pct;

  h_bridge_relay_sequencer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_if  (req_ch),
    .drv_if  (drv_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Stall the drive channel at the phase's rate
  always @(posedge clk_i) begin
    drv_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Predict on every accepted tick, check every drive transfer
  always @(posedge clk_i) begin
    drive_t got;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_tick(req_ch.request_valid, req_ch.requested_state);
      if (drv_ch.valid && drv_ch.ready) begin
        got.low_a  = drv_ch.drive_low_a;
        got.low_b  = drv_ch.drive_low_b;
        got.high_a = drv_ch.drive_high_a;
        got.high_b = drv_ch.drive_high_b;
        got.busy   = drv_ch.busy_res;
        got.last   = drv_ch.last_request;
        sb.check_drive(got);
      end
    end
  end

  // Write one register: setup phase, access phase, then an idle phase
  task automatic apb_write(hbrs_pkg::reg_idx_e idx, logic [hbrs_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hbrs_pkg::APB_AW'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one tick and hold it until the transfer; valid stays high afterwards
  task automatic push_tick(logic rv, logic [hbrs_pkg::STATE_W-1:0] st);
    req_ch.valid           <= 1'b1;
    req_ch.request_valid   <= rv;
    req_ch.requested_state <= st;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every drive due has arrived
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [hbrs_pkg::APB_DW-1:0] half_v;
    logic [hbrs_pkg::APB_DW-1:0] delay_v;
    logic                        mode_v;
    int                          count;
    sb                     = new();
    idle_pct               = 0;
    stall_pct              = 0;
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    req_ch.valid           = 1'b0;
    req_ch.request_valid   = 1'b0;
    req_ch.requested_state = hbrs_pkg::ST_GROUND;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every state, a request during the wait, an ignored state field
    apb_write(hbrs_pkg::REG_DELAY, 3);
    push_tick(1'b1, hbrs_pkg::ST_HVA);
    push_tick(1'b0, hbrs_pkg::ST_HIGHZ);
    push_tick(1'b1, hbrs_pkg::ST_HVB);
    repeat (4) push_tick(1'b0, hbrs_pkg::ST_GROUND);
    push_tick(1'b1, hbrs_pkg::ST_HIGHZ);
    repeat (4) push_tick(1'b0, hbrs_pkg::ST_HIGHZ);
    push_tick(1'b1, hbrs_pkg::ST_GROUND);
    repeat (4) push_tick(1'b0, hbrs_pkg::ST_GROUND);
    settle();

    // Directed: frequency mode without a period falls back to ground
    apb_write(hbrs_pkg::REG_MODE, 1);
    push_tick(1'b0, hbrs_pkg::ST_GROUND);
    settle();

    // Directed: requests held in frequency mode, the latest acts on return
    apb_write(hbrs_pkg::REG_HALF, 2);
    apb_write(hbrs_pkg::REG_MODE, 1);
    push_tick(1'b1, hbrs_pkg::ST_HVA);
    push_tick(1'b1, hbrs_pkg::ST_HIGHZ);
    repeat (4) push_tick(1'b0, hbrs_pkg::ST_GROUND);
    settle();
    apb_write(hbrs_pkg::REG_MODE, 0);
    push_tick(1'b0, hbrs_pkg::ST_GROUND);
    settle();

    // Random phases over register settings and idling patterns
    for (int p = 0; p < 8; p++) begin
      count = 255;
      case (p)
        0: begin mode_v = 1'b0; half_v = 0;        delay_v = 0;       end
        1: begin mode_v = 1'b1; half_v = 1;        delay_v = 0;       end
        2: begin mode_v = 1'b1; half_v = 5;        delay_v = 2;       end
        3: begin mode_v = 1'b0; half_v = 24'hFFFFFF; delay_v = 4;     end
        4: begin
          mode_v  = 1'b1;
          half_v  = 24'hFFFFFF;
          delay_v = 20'hFFFFF;
          count   = 60;
        end
        5: begin mode_v = 1'b1; half_v = 3;        delay_v = 7;       end
        6: begin mode_v = 1'b0; half_v = 0;        delay_v = $urandom_range(0, 6); end
        default: begin
          mode_v  = 1'b1;
          half_v  = $urandom_range(1, 20);
          delay_v = $urandom_range(0, 10);
        end
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      apb_write(hbrs_pkg::REG_DELAY, delay_v);
      apb_write(hbrs_pkg::REG_HALF, half_v);
      apb_write(hbrs_pkg::REG_MODE, mode_v);
      for (int n = 0; n < count; n++) begin
        // Hold off mid-phase until the drive channel has caught up
        if (n == count / 2)
          settle();
        if ($urandom_range(0, 99) < idle_pct) begin
          req_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
        push_tick($urandom_range(0, 99) < 25, hbrs_pkg::STATE_W'($urandom_range(0, 3)));
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
